/* src/sha256_byte_stream_hasher_defines.svh */
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher assertion macros
// Macros for the concurrent checks of the hasher controller.
// ---------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sbsh_pkg.sv */
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Word types, controller states, command struct and SHA-256 constants.
// ---------------------------------------------------------------------------
package sbsh_pkg;

    localparam int FILL_W  = 6;
    localparam int ROUND_W = 6;
    localparam int WIDX_W  = 3;

    localparam logic [FILL_W-1:0]  PAD_LIMIT  = 6'd56;
    localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [WIDX_W-1:0]  WORD_LAST  = 3'd7;
    localparam logic [7:0]         MARK_BYTE  = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0]       digest_word;
        logic [WIDX_W-1:0] word_index;
        logic              last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BS_INPUT,
        BS_MARK,
        BS_ZERO,
        BS_LEN
    } t_byte_sel;

    typedef struct packed {
        logic               push;
        t_byte_sel          sel;
        logic [2:0]         len_idx;
        logic               count;
        logic               load_work;
        logic               round;
        logic [ROUND_W-1:0] round_idx;
        logic               fold;
        logic               restart;
        logic [WIDX_W-1:0]  out_idx;
    } t_dp_cmd;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

/* src/sbsh_ctrl.sv */
// ---------------------------------------------------------------------------
// SHA-256 hasher controller
// Sequences byte intake, padding, the 64 rounds and the digest readout.
// ---------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_defines.svh"

module sbsh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_byte_valid,
    input  logic            i_end_of_message,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sbsh_pkg::t_dp_cmd o_cmd
);
    import sbsh_pkg::*;

    t_state              r_state,   n_state;
    logic [FILL_W-1:0]   r_fill,    n_fill;
    logic [ROUND_W-1:0]  r_round,   n_round;
    logic [WIDX_W-1:0]   r_widx,    n_widx;
    logic                r_closing, n_closing;
    logic                r_sent80,  n_sent80;
    logic                r_in_len,  n_in_len;
    logic                r_done,    n_done;

    logic      w_in_acc;
    logic      w_out_acc;
    t_byte_sel w_pad_sel;

    assign w_in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_acc = (r_state == ST_OUT) && !i_out_stall;

    // Padding byte choice: the marker first, then zeros up to the length field.
    always_comb begin
        if (!r_sent80) begin
            w_pad_sel = BS_MARK;
        end else if (r_in_len || (r_fill == PAD_LIMIT)) begin
            w_pad_sel = BS_LEN;
        end else begin
            w_pad_sel = BS_ZERO;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_round   = r_round;
        n_widx    = r_widx;
        n_closing = r_closing;
        n_sent80  = r_sent80;
        n_in_len  = r_in_len;
        n_done    = r_done;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_closing = i_end_of_message;
                    n_sent80  = 1'b0;
                    n_in_len  = 1'b0;
                    n_done    = 1'b0;
                    if (i_byte_valid && (r_fill == FILL_LAST)) begin
                        n_fill  = '0;
                        n_round = '0;
                        n_state = ST_ROUND;
                    end else begin
                        n_fill = r_fill + FILL_W'(i_byte_valid);
                        if (i_end_of_message) begin
                            n_state = ST_PAD;
                        end
                    end
                end
            end
            ST_ROUND: begin
                n_round = r_round + 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_done) begin
                    n_widx  = '0;
                    n_state = ST_OUT;
                end else if (r_closing) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                n_sent80 = 1'b1;
                if (w_pad_sel == BS_LEN) begin
                    n_in_len = 1'b1;
                end
                if (r_fill == FILL_LAST) begin
                    n_fill  = '0;
                    n_round = '0;
                    n_done  = (w_pad_sel == BS_LEN);
                    n_state = ST_ROUND;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            ST_OUT: begin
                if (w_out_acc) begin
                    n_widx = r_widx + 1'b1;
                    if (r_widx == WORD_LAST) begin
                        n_fill    = '0;
                        n_closing = 1'b0;
                        n_sent80  = 1'b0;
                        n_in_len  = 1'b0;
                        n_done    = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.sel       = BS_INPUT;
        o_cmd.len_idx   = r_fill[2:0];
        o_cmd.round_idx = r_round;
        o_cmd.out_idx   = r_widx;
        o_in_stall      = (r_state != ST_IDLE);
        o_out_valid     = (r_state == ST_OUT);
        case (r_state)
            ST_IDLE: begin
                o_cmd.push      = w_in_acc && i_byte_valid;
                o_cmd.count     = w_in_acc && i_byte_valid;
                o_cmd.load_work = w_in_acc && i_byte_valid && (r_fill == FILL_LAST);
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
            end
            ST_PAD: begin
                o_cmd.push      = 1'b1;
                o_cmd.sel       = w_pad_sel;
                o_cmd.load_work = (r_fill == FILL_LAST);
            end
            ST_OUT: begin
                o_cmd.restart = w_out_acc && (r_widx == WORD_LAST);
            end
            default: begin
                o_cmd.restart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_round   <= '0;
            r_widx    <= '0;
            r_closing <= 1'b0;
            r_sent80  <= 1'b0;
            r_in_len  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_round   <= n_round;
            r_widx    <= n_widx;
            r_closing <= n_closing;
            r_sent80  <= n_sent80;
            r_in_len  <= n_in_len;
            r_done    <= n_done;
        end
    end

    `SBSH_ASSERT_NEXT(a_round_ends, i_clk, i_rst_n, (r_state == ST_ROUND) && (r_round == ROUND_LAST), r_state == ST_FOLD, "round counter did not hand over to fold")
    `SBSH_ASSERT_NOW(a_len_field_place, i_clk, i_rst_n, (r_state == ST_PAD) && r_in_len, r_fill >= PAD_LIMIT, "length field pushed below its place in the block")
    `SBSH_ASSERT_NOW(a_done_closing, i_clk, i_rst_n, r_done, r_closing && r_sent80 && r_in_len, "digest ready without finished padding")
    `SBSH_ASSERT_NEXT(a_restart_clean, i_clk, i_rst_n, w_out_acc && (r_widx == WORD_LAST), (r_state == ST_IDLE) && (r_fill == '0), "last digest word did not restart the message")

endmodule

/* src/sbsh_dp.sv */
// ---------------------------------------------------------------------------
// SHA-256 hasher datapath
// Chaining words, bit count, block window with schedule, and round logic.
// ---------------------------------------------------------------------------
module sbsh_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbsh_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]        i_data_byte,
    output sbsh_pkg::t_out_item o_out
);
    import sbsh_pkg::*;

    logic [31:0] r_hash [8];
    logic [31:0] r_wk   [8];
    logic [31:0] r_win  [16];
    logic [63:0] r_bits;

    logic [7:0]  w_byte;
    logic [5:0]  w_len_lsb;
    logic [31:0] w_sched;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Length byte i of the big-endian count sits at bit offset 8 * (7 - i).
    assign w_len_lsb = {~i_cmd.len_idx, 3'b000};

    always_comb begin
        case (i_cmd.sel)
            BS_INPUT: w_byte = i_data_byte;
            BS_MARK:  w_byte = MARK_BYTE;
            BS_ZERO:  w_byte = 8'h00;
            BS_LEN:   w_byte = r_bits[w_len_lsb +: 8];
            default:  w_byte = 8'h00;
        endcase
    end

    assign w_sched = r_win[0]
                   + (rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3))
                   + r_win[9]
                   + (rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10));

    assign w_t1 = r_wk[7]
                + (rotr(r_wk[4], 6) ^ rotr(r_wk[4], 11) ^ rotr(r_wk[4], 25))
                + ((r_wk[4] & r_wk[5]) ^ (~r_wk[4] & r_wk[6]))
                + K_TABLE[i_cmd.round_idx]
                + r_win[0];

    assign w_t2 = (rotr(r_wk[0], 2) ^ rotr(r_wk[0], 13) ^ rotr(r_wk[0], 22))
                + ((r_wk[0] & r_wk[1]) ^ (r_wk[0] & r_wk[2]) ^ (r_wk[1] & r_wk[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= H_INIT;
            r_bits <= '0;
        end else if (i_cmd.restart) begin
            r_hash <= H_INIT;
            r_bits <= '0;
        end else begin
            if (i_cmd.count) begin
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.fold) begin
                for (int k = 0; k < 8; k++) begin
                    r_hash[k] <= r_hash[k] + r_wk[k];
                end
            end
        end
    end

    // The window shifts a byte in at the bottom while gathering, so word 0
    // holds the first four bytes of the block; each round shifts a word out.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= {r_win[j][23:0], r_win[j+1][31:24]};
            end
            r_win[15] <= {r_win[15][23:0], w_byte};
        end else if (i_cmd.round) begin
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[15] <= w_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            r_wk <= r_hash;
        end else if (i_cmd.round) begin
            r_wk[0] <= w_t1 + w_t2;
            r_wk[1] <= r_wk[0];
            r_wk[2] <= r_wk[1];
            r_wk[3] <= r_wk[2];
            r_wk[4] <= r_wk[3] + w_t1;
            r_wk[5] <= r_wk[4];
            r_wk[6] <= r_wk[5];
            r_wk[7] <= r_wk[6];
        end
    end

    assign o_out.digest_word = r_hash[i_cmd.out_idx];
    assign o_out.word_index  = i_cmd.out_idx;
    assign o_out.last_word   = (i_cmd.out_idx == WORD_LAST);

endmodule

/* src/sha256_byte_stream_hasher.sv */
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message given one byte per input word and returns the digest as
// eight 32-bit words.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in  (data_byte, byte_valid, end_of_message)
// output    out        o_out_valid / i_out_stall o_out (digest_word, word_index, last_word)
//
// A word that carries a byte is taken only while the hasher is idle; the 64th
// byte of a block starts the compression, which runs the 64 rounds and then
// folds the working variables into the chaining words, so a long message
// stalls its input during every compression, as the single round unit is shared.
// A closing word adds 9 to 72 padding bytes and one or two compressions,
// then the eight digest words leave one per cycle unless stalled.
// Reset is synchronous and active low; it loads the initial hash values and
// clears the bit count and fill count. No input word is taken while a block
// is compressed, padding runs or the digest is being read out.
//
// The controller owns fill level, round counter and padding progress; the
// datapath holds the chaining words, the 64-bit bit count, the 16-word block
// window (which doubles as the message schedule) and the round logic.
// ---------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sbsh_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sbsh_pkg::t_out_item o_out
);
    import sbsh_pkg::*;

    // Command bundle from the controller to the datapath.
    t_dp_cmd w_cmd;

    sbsh_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_byte_valid     (i_in.byte_valid),
        .i_end_of_message (i_in.end_of_message),
        .o_in_stall       (o_in_stall),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cmd            (w_cmd)
    );

    // The datapath only sees the byte itself; the flags steer the controller.
    sbsh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_byte (i_in.data_byte),
        .o_out       (o_out)
    );

endmodule
